// ===== hw/rtl/connectivity_witness_update_macros.svh =====
// Assertion macros for the connectivity witness update block
`ifndef CONNECTIVITY_WITNESS_UPDATE_MACROS_SVH
`define CONNECTIVITY_WITNESS_UPDATE_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define CWU_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset
`define CWU_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/cwu_pkg.sv =====
// Types, codes and helper functions shared by the connectivity witness update block
`default_nettype none

package cwu_pkg;

    localparam int SLOT_MAX = 8;
    localparam int LABEL_W  = 3;
    localparam int COUNT_W  = 4;

    localparam logic [1:0] OP_ADD_VERTEX = 2'd0;
    localparam logic [1:0] OP_ADD_EDGE   = 2'd1;
    localparam logic [1:0] OP_FORGET     = 2'd2;
    localparam logic [1:0] OP_JOIN       = 2'd3;

    localparam logic [1:0] TAG_EMPTY   = 2'd0;
    localparam logic [1:0] TAG_GROWING = 2'd1;
    localparam logic [1:0] TAG_CLOSED  = 2'd2;
    localparam logic [1:0] TAG_BROKEN  = 2'd3;

    typedef logic [LABEL_W-1:0]                label_t;
    typedef logic [SLOT_MAX-1:0]               slot_mask_t;
    typedef logic [SLOT_MAX-1:0][LABEL_W-1:0]  roots_t;
    typedef logic [SLOT_MAX-1:0][SLOT_MAX-1:0] matrix_t;
    typedef logic [COUNT_W-1:0]                count_t;

    typedef struct packed {
        logic load;
        logic commit_simple;
        logic build_adj;
        logic square;
        logic commit_join;
    } dp_cmd_t;

    typedef struct packed {
        logic is_join;
    } dp_status_t;

    function automatic label_t lowest_slot(input slot_mask_t m);
        label_t r;
        r = '0;
        for (int i = SLOT_MAX - 1; i >= 0; i--)
        begin
            if (m[i])
            begin
                r = label_t'(i);
            end
        end
        return r;
    endfunction

    // a component is counted at the slot that carries its own label
    function automatic count_t count_components(input slot_mask_t present, input roots_t roots);
        count_t c;
        c = '0;
        for (int i = 0; i < SLOT_MAX; i++)
        begin
            if (present[i] && roots[i] == label_t'(i))
            begin
                c = c + count_t'(1);
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/cwu_ctrl.sv =====
// Sequencer for the connectivity witness update: handshakes and datapath commands
`default_nettype none

module cwu_ctrl #(
    parameter int BAG_SLOTS = 8
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output cwu_pkg::dp_cmd_t        cmd,
    input  wire cwu_pkg::dp_status_t status
);

    localparam int NSLOT       = (BAG_SLOTS < cwu_pkg::SLOT_MAX) ? BAG_SLOTS : cwu_pkg::SLOT_MAX;
    localparam int JOIN_ROUNDS = $clog2(NSLOT);
    localparam int ROUND_W     = $clog2(JOIN_ROUNDS) + 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SQUARE,
        S_FINISH
    } state_t;

    state_t               state_reg, state_next;
    logic [ROUND_W-1:0]   round_reg, round_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 out_free;

    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        round_next     = round_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd            = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (status.is_join)
                begin
                    cmd.build_adj = 1'b1;
                    round_next    = '0;
                    state_next    = S_SQUARE;
                end
                else if (out_free)
                begin
                    cmd.commit_simple = 1'b1;
                    out_valid_next    = 1'b1;
                    state_next        = S_IDLE;
                end
            end
            S_SQUARE:
            begin
                cmd.square = 1'b1;
                if (round_reg == ROUND_W'(JOIN_ROUNDS - 1))
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    round_next = round_reg + ROUND_W'(1);
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    cmd.commit_join = 1'b1;
                    out_valid_next  = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            round_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            round_reg     <= round_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/cwu_datapath.sv =====
// Witness state, per-operation update logic and the join reachability matrix
`default_nettype none

module cwu_datapath #(
    parameter int BAG_SLOTS = 8
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire cwu_pkg::dp_cmd_t     cmd,
    output cwu_pkg::dp_status_t       status,
    input  wire logic [1:0]           op,
    input  wire logic [2:0]           vertex_a,
    input  wire logic [2:0]           vertex_b,
    input  wire logic [7:0]           other_present,
    input  wire logic [23:0]          other_roots,
    input  wire logic [1:0]           other_tag,
    output logic [1:0]                tag_out,
    output logic [7:0]                present_out,
    output logic [23:0]               roots_out,
    output logic [3:0]                component_count,
    output logic                      accept,
    output logic                      error
);

    localparam int NSLOT = (BAG_SLOTS < cwu_pkg::SLOT_MAX) ? BAG_SLOTS : cwu_pkg::SLOT_MAX;
    localparam cwu_pkg::slot_mask_t SLOT_MASK = cwu_pkg::slot_mask_t'((1 << NSLOT) - 1);

    // item word
    logic [1:0]           op_reg;
    cwu_pkg::label_t      a_reg, b_reg;
    cwu_pkg::slot_mask_t  opres_reg;
    cwu_pkg::roots_t      oroots_reg;
    logic [1:0]           otag_reg;

    // witness
    cwu_pkg::slot_mask_t  present_reg, present_next;
    cwu_pkg::roots_t      roots_reg, roots_next;
    logic [1:0]           tag_reg, tag_next;
    cwu_pkg::count_t      count_reg, count_next;
    logic                 accept_reg, accept_next;
    logic                 error_reg, error_next;

    cwu_pkg::matrix_t     reach_reg, reach_next;

    cwu_pkg::slot_mask_t  s_present, j_present, a_bit, group, rest, all_slots;
    cwu_pkg::roots_t      s_roots, j_roots;
    logic [1:0]           s_tag, j_tag;
    logic                 s_err, a_ok, pa, pb;
    cwu_pkg::label_t      ra, rb, merge_root, rest_root;
    cwu_pkg::count_t      cur_count;
    cwu_pkg::matrix_t     adj, sq;

    assign status.is_join = (op_reg == cwu_pkg::OP_JOIN);

    // vertex, edge and forget operations
    always_comb
    begin
        a_ok       = int'(a_reg) < NSLOT;
        pa         = present_reg[a_reg];
        pb         = present_reg[b_reg];
        ra         = roots_reg[a_reg];
        rb         = roots_reg[b_reg];
        merge_root = (ra < rb) ? ra : rb;
        a_bit      = cwu_pkg::slot_mask_t'(1) << a_reg;
        for (int i = 0; i < cwu_pkg::SLOT_MAX; i++)
        begin
            group[i] = present_reg[i] && (roots_reg[i] == ra);
        end
        rest      = group & ~a_bit;
        rest_root = cwu_pkg::lowest_slot(rest);
        cur_count = cwu_pkg::count_components(present_reg, roots_reg);

        s_present = present_reg;
        s_roots   = roots_reg;
        s_tag     = tag_reg;
        s_err     = 1'b0;
        case (op_reg)
            cwu_pkg::OP_ADD_VERTEX:
            begin
                if (!a_ok || pa)
                begin
                    s_err = 1'b1;
                end
                else
                begin
                    s_present        = present_reg | a_bit;
                    s_roots[a_reg]   = a_reg;
                    s_tag            = tag_reg | cwu_pkg::TAG_GROWING;
                end
            end
            cwu_pkg::OP_ADD_EDGE:
            begin
                if (pa != pb)
                begin
                    s_err = 1'b1;
                end
                else if (pa && ra != rb)
                begin
                    for (int i = 0; i < cwu_pkg::SLOT_MAX; i++)
                    begin
                        if (present_reg[i] && (roots_reg[i] == ra || roots_reg[i] == rb))
                        begin
                            s_roots[i] = merge_root;
                        end
                    end
                end
            end
            cwu_pkg::OP_FORGET:
            begin
                if (!pa)
                begin
                    s_err = 1'b1;
                end
                else
                begin
                    if (rest == '0)
                    begin
                        // last member of its component gone
                        if (tag_reg == cwu_pkg::TAG_GROWING)
                        begin
                            s_tag = (cur_count >= cwu_pkg::count_t'(2)) ?
                                    cwu_pkg::TAG_BROKEN : cwu_pkg::TAG_CLOSED;
                        end
                    end
                    else
                    begin
                        for (int i = 0; i < cwu_pkg::SLOT_MAX; i++)
                        begin
                            if (rest[i])
                            begin
                                s_roots[i] = rest_root;
                            end
                        end
                    end
                    s_present      = present_reg & ~a_bit;
                    s_roots[a_reg] = '0;
                end
            end
            default:
            begin
                s_err = 1'b0;
            end
        endcase
    end

    // join: adjacency of both partitions, squared in the sequencer's square state, then min slot per row
    always_comb
    begin
        all_slots = present_reg | opres_reg;
        for (int i = 0; i < cwu_pkg::SLOT_MAX; i++)
        begin
            for (int j = 0; j < cwu_pkg::SLOT_MAX; j++)
            begin
                adj[i][j] = all_slots[i] && ((i == j) ||
                            (present_reg[i] && present_reg[j] && roots_reg[i] == roots_reg[j]) ||
                            (opres_reg[i] && opres_reg[j] && oroots_reg[i] == oroots_reg[j]));
            end
        end
        for (int i = 0; i < cwu_pkg::SLOT_MAX; i++)
        begin
            sq[i] = '0;
            for (int j = 0; j < cwu_pkg::SLOT_MAX; j++)
            begin
                if (reach_reg[i][j])
                begin
                    sq[i] = sq[i] | reach_reg[j];
                end
            end
        end
        for (int i = 0; i < cwu_pkg::SLOT_MAX; i++)
        begin
            j_roots[i] = all_slots[i] ? cwu_pkg::lowest_slot(reach_reg[i]) : '0;
        end
        j_present = all_slots;
        if (tag_reg <= cwu_pkg::TAG_GROWING && otag_reg <= cwu_pkg::TAG_GROWING)
        begin
            j_tag = cwu_pkg::TAG_GROWING;
        end
        else if ((tag_reg == cwu_pkg::TAG_EMPTY && otag_reg == cwu_pkg::TAG_CLOSED) ||
                 (tag_reg == cwu_pkg::TAG_CLOSED && otag_reg == cwu_pkg::TAG_EMPTY))
        begin
            j_tag = cwu_pkg::TAG_CLOSED;
        end
        else
        begin
            j_tag = cwu_pkg::TAG_BROKEN;
        end
        if (tag_reg == cwu_pkg::TAG_EMPTY && otag_reg == cwu_pkg::TAG_EMPTY)
        begin
            j_present = '0;
            j_roots   = '0;
            j_tag     = cwu_pkg::TAG_EMPTY;
        end
    end

    always_comb
    begin
        present_next = present_reg;
        roots_next   = roots_reg;
        tag_next     = tag_reg;
        error_next   = error_reg;
        if (cmd.commit_simple)
        begin
            present_next = s_present;
            roots_next   = s_roots;
            tag_next     = s_tag;
            error_next   = s_err;
        end
        else if (cmd.commit_join)
        begin
            present_next = j_present;
            roots_next   = j_roots;
            tag_next     = j_tag;
            error_next   = 1'b0;
        end
        count_next  = cwu_pkg::count_components(present_next, roots_next);
        accept_next = (tag_next != cwu_pkg::TAG_BROKEN) && (count_next <= cwu_pkg::count_t'(1));
    end

    always_comb
    begin
        reach_next = reach_reg;
        if (cmd.build_adj)
        begin
            reach_next = adj;
        end
        else if (cmd.square)
        begin
            reach_next = sq;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg     <= op;
            a_reg      <= vertex_a;
            b_reg      <= vertex_b;
            opres_reg  <= other_present & SLOT_MASK;
            oroots_reg <= other_roots;
            otag_reg   <= other_tag;
        end
        reach_reg <= reach_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            present_reg <= '0;
            roots_reg   <= '0;
            tag_reg     <= cwu_pkg::TAG_EMPTY;
            count_reg   <= '0;
            accept_reg  <= 1'b0;
            error_reg   <= 1'b0;
        end
        else if (cmd.commit_simple || cmd.commit_join)
        begin
            present_reg <= present_next;
            roots_reg   <= roots_next;
            tag_reg     <= tag_next;
            count_reg   <= count_next;
            accept_reg  <= accept_next;
            error_reg   <= error_next;
        end
    end

    // state only changes at a commit, which waits for the output word to be taken
    assign tag_out         = tag_reg;
    assign present_out     = present_reg;
    assign roots_out       = roots_reg;
    assign component_count = count_reg;
    assign accept          = accept_reg;
    assign error           = error_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/connectivity_witness_update.sv =====
// Vertex, edge and forget operations are loaded into the item word and committed from the execute state;
// a join builds the reachability matrix, squares it in the square state and commits from the finish state.
// A new input word is taken only in the idle state, after the previous word has been committed.
// A new input word is taken while the previous result waits on a stalled output.
// Reset (rst_n low, asynchronous) empties the witness: no slots, empty tag, no output word.
`default_nettype none

module connectivity_witness_update #(
    parameter int BAG_SLOTS = 8
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  op,
    input  wire logic [2:0]  vertex_a,
    input  wire logic [2:0]  vertex_b,
    input  wire logic [7:0]  other_present,
    input  wire logic [23:0] other_roots,
    input  wire logic [1:0]  other_tag,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [1:0]       tag_out,
    output logic [7:0]       present_out,
    output logic [23:0]      roots_out,
    output logic [3:0]       component_count,
    output logic             accept,
    output logic             error
);

    cwu_pkg::dp_cmd_t    cmd;
    cwu_pkg::dp_status_t status;

    cwu_ctrl #(
        .BAG_SLOTS (BAG_SLOTS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .status    (status)
    );

    cwu_datapath #(
        .BAG_SLOTS (BAG_SLOTS)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .op              (op),
        .vertex_a        (vertex_a),
        .vertex_b        (vertex_b),
        .other_present   (other_present),
        .other_roots     (other_roots),
        .other_tag       (other_tag),
        .tag_out         (tag_out),
        .present_out     (present_out),
        .roots_out       (roots_out),
        .component_count (component_count),
        .accept          (accept),
        .error           (error)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/cwu_checker.sv =====
// Port-level checks for the connectivity witness update, bound to the top level
`default_nettype none
`include "connectivity_witness_update_macros.svh"

module cwu_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_stall,
    input wire logic [1:0]  op,
    input wire logic [2:0]  vertex_a,
    input wire logic [2:0]  vertex_b,
    input wire logic [7:0]  other_present,
    input wire logic [23:0] other_roots,
    input wire logic [1:0]  other_tag,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [1:0]  tag_out,
    input wire logic [7:0]  present_out,
    input wire logic [23:0] roots_out,
    input wire logic [3:0]  component_count,
    input wire logic        accept,
    input wire logic        error
);

    `CWU_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(tag_out) && $stable(present_out) && $stable(roots_out) && $stable(component_count) && $stable(accept) && $stable(error), "output word changed while stalled")

    `CWU_ASSERT_IMP(a_accept_rule, clk, rst_n, out_valid, accept == ((tag_out != cwu_pkg::TAG_BROKEN) && (component_count <= 4'd1)), "accept disagrees with tag and count")

    `CWU_ASSERT_IMP(a_count_bound, clk, rst_n, out_valid, component_count <= 4'($countones(present_out)), "more components than slots")

    `CWU_ASSERT_IMP(a_empty_tag, clk, rst_n, out_valid && (tag_out == cwu_pkg::TAG_EMPTY), present_out == 8'd0, "empty tag with slots present")

endmodule

bind connectivity_witness_update cwu_checker u_checker (.*);

`default_nettype wire

// ===== tb/sv/tb.sv =====
// Self-checking testbench for connectivity_witness_update: directed table then random words
module tb;
    import cwu_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [1:0]  op;
        logic [2:0]  va;
        logic [2:0]  vb;
        logic [7:0]  opres;
        logic [23:0] oroots;
        logic [1:0]  otag;
    } word_in_t;

    typedef struct packed {
        logic [1:0]  tag;
        logic [7:0]  present;
        logic [23:0] roots;
        logic [3:0]  count;
        logic        accept;
        logic        error;
    } word_out_t;

    typedef struct packed {
        word_in_t  w;
        logic      typed;
        word_out_t want;
    } row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  op = '0;
    logic [2:0]  vertex_a = '0;
    logic [2:0]  vertex_b = '0;
    logic [7:0]  other_present = '0;
    logic [23:0] other_roots = '0;
    logic [1:0]  other_tag = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  tag_out;
    logic [7:0]  present_out;
    logic [23:0] roots_out;
    logic [3:0]  component_count;
    logic        accept;
    logic        error;

    // predictor copy of the witness
    slot_mask_t  wit_present = '0;
    roots_t      wit_root = '0;
    logic [1:0]  wit_tag = TAG_EMPTY;

    word_out_t   witness_due[$];
    int          failures = 0;
    int          results_seen = 0;
    int          hold_left = 0;
    int          sender_idle_pct = 0;
    int          receiver_stall_pct = 0;

    connectivity_witness_update uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .op              (op),
        .vertex_a        (vertex_a),
        .vertex_b        (vertex_b),
        .other_present   (other_present),
        .other_roots     (other_roots),
        .other_tag       (other_tag),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .tag_out         (tag_out),
        .present_out     (present_out),
        .roots_out       (roots_out),
        .component_count (component_count),
        .accept          (accept),
        .error           (error)
    );

    always #5 clk = ~clk;

    initial
    begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

    function automatic logic [2:0] least_member(input logic [7:0] m);
        logic [2:0] r;
        logic       found;
        r = '0;
        found = 1'b0;
        for (int i = 0; i < 8; i++)
        begin
            if (m[i] && !found)
            begin
                r = i[2:0];
                found = 1'b1;
            end
        end
        return r;
    endfunction

    function automatic logic [3:0] component_tally(input slot_mask_t p, input roots_t rt);
        logic [3:0] c;
        c = '0;
        for (int i = 0; i < 8; i++)
        begin
            if (p[i] && rt[i] == i[2:0])
            begin
                c = c + 4'd1;
            end
        end
        return c;
    endfunction

    // applies one operation to the predictor witness and returns the word it should give
    function automatic word_out_t next_witness(input word_in_t w);
        word_out_t  r;
        logic [7:0] rest;
        logic [7:0] all_slots;
        logic [7:0] adj [8];
        logic [7:0] reach [8];
        logic [2:0] ra;
        logic [2:0] rb;
        logic [2:0] low;
        logic [1:0] qn;
        logic       pa;
        logic       pb;
        logic       same_here;
        logic       same_there;
        r = '0;
        case (w.op)
            OP_ADD_VERTEX:
            begin
                if (wit_present[w.va])
                begin
                    r.error = 1'b1;
                end
                else
                begin
                    wit_present[w.va] = 1'b1;
                    wit_root[w.va] = w.va;
                    wit_tag = wit_tag | TAG_GROWING;
                end
            end
            OP_ADD_EDGE:
            begin
                pa = wit_present[w.va];
                pb = wit_present[w.vb];
                if (pa != pb)
                begin
                    r.error = 1'b1;
                end
                else if (pa && wit_root[w.va] != wit_root[w.vb])
                begin
                    ra = wit_root[w.va];
                    rb = wit_root[w.vb];
                    low = (ra < rb) ? ra : rb;
                    for (int i = 0; i < 8; i++)
                    begin
                        if (wit_present[i] && (wit_root[i] == ra || wit_root[i] == rb))
                        begin
                            wit_root[i] = low;
                        end
                    end
                end
            end
            OP_FORGET:
            begin
                if (!wit_present[w.va])
                begin
                    r.error = 1'b1;
                end
                else
                begin
                    rest = '0;
                    for (int i = 0; i < 8; i++)
                    begin
                        if (wit_present[i] && wit_root[i] == wit_root[w.va] && i != w.va)
                        begin
                            rest[i] = 1'b1;
                        end
                    end
                    if (rest == 0)
                    begin
                        // last member gone: the component is closed off
                        if (wit_tag == TAG_GROWING)
                        begin
                            wit_tag = (component_tally(wit_present, wit_root) >= 2) ?
                                      TAG_BROKEN : TAG_CLOSED;
                        end
                    end
                    else
                    begin
                        low = least_member(rest);
                        for (int i = 0; i < 8; i++)
                        begin
                            if (rest[i])
                            begin
                                wit_root[i] = low;
                            end
                        end
                    end
                    wit_present[w.va] = 1'b0;
                    wit_root[w.va] = '0;
                end
            end
            default:
            begin
                if (wit_tag == TAG_EMPTY && w.otag == TAG_EMPTY)
                begin
                    wit_present = '0;
                    wit_root = '0;
                end
                else
                begin
                    if (wit_tag <= TAG_GROWING && w.otag <= TAG_GROWING)
                    begin
                        qn = TAG_GROWING;
                    end
                    else if ((wit_tag == TAG_EMPTY && w.otag == TAG_CLOSED) ||
                             (wit_tag == TAG_CLOSED && w.otag == TAG_EMPTY))
                    begin
                        qn = TAG_CLOSED;
                    end
                    else
                    begin
                        qn = TAG_BROKEN;
                    end
                    all_slots = wit_present | w.opres;
                    // slots sharing a label on either side are linked
                    for (int i = 0; i < 8; i++)
                    begin
                        adj[i] = '0;
                        if (all_slots[i])
                        begin
                            adj[i][i] = 1'b1;
                            for (int j = 0; j < 8; j++)
                            begin
                                same_here = wit_present[i] && wit_present[j] &&
                                            wit_root[i] == wit_root[j];
                                same_there = w.opres[i] && w.opres[j] &&
                                             w.oroots[3*i +: 3] == w.oroots[3*j +: 3];
                                if (same_here || same_there)
                                begin
                                    adj[i][j] = 1'b1;
                                end
                            end
                        end
                        reach[i] = adj[i];
                    end
                    for (int k = 0; k < 8; k++)
                    begin
                        for (int i = 0; i < 8; i++)
                        begin
                            for (int j = 0; j < 8; j++)
                            begin
                                if (reach[i][j])
                                begin
                                    reach[i] = reach[i] | adj[j];
                                end
                            end
                        end
                    end
                    for (int i = 0; i < 8; i++)
                    begin
                        wit_root[i] = all_slots[i] ? least_member(reach[i]) : 3'd0;
                    end
                    wit_present = all_slots;
                    wit_tag = qn;
                end
            end
        endcase
        for (int i = 0; i < 8; i++)
        begin
            r.roots[3*i +: 3] = wit_present[i] ? wit_root[i] : 3'd0;
        end
        r.tag = wit_tag;
        r.present = wit_present;
        r.count = component_tally(wit_present, wit_root);
        r.accept = (wit_tag != TAG_BROKEN) && (r.count <= 1);
        return r;
    endfunction

    function automatic row_t stim_row(input logic [1:0] o, input logic [2:0] a,
                                      input logic [2:0] b, input logic [7:0] p,
                                      input logic [23:0] rt, input logic [1:0] t);
        row_t r;
        r = '0;
        r.w.op = o;
        r.w.va = a;
        r.w.vb = b;
        r.w.opres = p;
        r.w.oroots = rt;
        r.w.otag = t;
        return r;
    endfunction

    function automatic row_t known(input row_t r, input logic [1:0] t, input logic [7:0] p,
                                   input logic [23:0] rt, input logic [3:0] c,
                                   input logic acc, input logic err);
        row_t k;
        k = r;
        k.typed = 1'b1;
        k.want.tag = t;
        k.want.present = p;
        k.want.roots = rt;
        k.want.count = c;
        k.want.accept = acc;
        k.want.error = err;
        return k;
    endfunction

    function automatic logic [2:0] pick_slot(input logic [7:0] m);
        int s;
        do
            s = $urandom_range(0, 7);
        while (!m[s]);
        return s[2:0];
    endfunction

    // mostly well-formed operands drawn from the current partition, the rest noise
    function automatic word_in_t random_word();
        word_in_t w;
        int       roll;
        w.op = 2'($urandom_range(0, 3));
        w.va = 3'($urandom_range(0, 7));
        w.vb = 3'($urandom_range(0, 7));
        w.opres = 8'($urandom);
        w.oroots = 24'($urandom);
        w.otag = 2'($urandom_range(0, 3));
        roll = $urandom_range(0, 99);
        if (roll < 30)
        begin
            w.op = OP_ADD_VERTEX;
            if ($urandom_range(0, 9) < 8 && wit_present != 8'hFF)
            begin
                w.va = pick_slot(~wit_present);
            end
        end
        else if (roll < 60)
        begin
            w.op = OP_ADD_EDGE;
            if ($urandom_range(0, 9) < 8 && wit_present != 0)
            begin
                w.va = pick_slot(wit_present);
                w.vb = pick_slot(wit_present);
            end
        end
        else if (roll < 85)
        begin
            w.op = OP_FORGET;
            if ($urandom_range(0, 9) < 8 && wit_present != 0)
            begin
                w.va = pick_slot(wit_present);
            end
        end
        else
        begin
            w.op = OP_JOIN;
            if ($urandom_range(0, 1) == 1)
            begin
                // few distinct labels, so the second witness has larger components
                for (int i = 0; i < 8; i++)
                begin
                    w.oroots[3*i +: 3] = 3'($urandom_range(0, 2));
                end
            end
        end
        return w;
    endfunction

    task automatic send_word(input word_in_t w, input logic typed, input word_out_t want);
        word_out_t got;
        if ($urandom_range(0, 99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid <= 1'b1;
        op <= w.op;
        vertex_a <= w.va;
        vertex_b <= w.vb;
        other_present <= w.opres;
        other_roots <= w.oroots;
        other_tag <= w.otag;
        do
            @(posedge clk);
        while (in_stall);
        got = next_witness(w);
        witness_due.push_back(typed ? want : got);
    endtask

    function automatic void compare_field(input string name, input logic [31:0] want,
                                          input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            failures++;
        end
    endfunction

    always @(posedge clk)
    begin
        word_out_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (witness_due.size() == 0)
            begin
                $error("result word with nothing expected");
                failures++;
            end
            else
            begin
                want = witness_due.pop_front();
                compare_field("tag_out", 32'(want.tag), 32'(tag_out));
                compare_field("present_out", 32'(want.present), 32'(present_out));
                compare_field("roots_out", 32'(want.roots), 32'(roots_out));
                compare_field("component_count", 32'(want.count), 32'(component_count));
                compare_field("accept", 32'(want.accept), 32'(accept));
                compare_field("error", 32'(want.error), 32'(error));
            end
            results_seen++;
            // long hold-off so the block backs up into its input
            if (results_seen == 150 || results_seen == 700)
            begin
                hold_left = 120;
            end
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
        end
    end

    initial
    begin
        row_t rows[$];
        int   guard;
        rows.push_back(known(stim_row(OP_FORGET, 3'd0, 3'd0, 8'h00, 24'h000000, TAG_EMPTY),
                             TAG_EMPTY, 8'h00, 24'h000000, 4'd0, 1'b1, 1'b1));
        rows.push_back(known(stim_row(OP_ADD_EDGE, 3'd0, 3'd7, 8'h00, 24'h000000, TAG_EMPTY),
                             TAG_EMPTY, 8'h00, 24'h000000, 4'd0, 1'b1, 1'b0));
        rows.push_back(known(stim_row(OP_JOIN, 3'd0, 3'd0, 8'hFF, 24'hFFFFFF, TAG_EMPTY),
                             TAG_EMPTY, 8'h00, 24'h000000, 4'd0, 1'b1, 1'b0));
        rows.push_back(known(stim_row(OP_ADD_VERTEX, 3'd7, 3'd0, 8'h00, 24'h000000, TAG_EMPTY),
                             TAG_GROWING, 8'h80, 24'hE00000, 4'd1, 1'b1, 1'b0));
        rows.push_back(known(stim_row(OP_ADD_VERTEX, 3'd7, 3'd0, 8'h00, 24'h000000, TAG_EMPTY),
                             TAG_GROWING, 8'h80, 24'hE00000, 4'd1, 1'b1, 1'b1));
        rows.push_back(stim_row(OP_ADD_VERTEX, 3'd0, 3'd0, 8'h00, 24'h000000, TAG_EMPTY));
        rows.push_back(stim_row(OP_ADD_EDGE, 3'd0, 3'd3, 8'h00, 24'h000000, TAG_EMPTY));
        rows.push_back(stim_row(OP_ADD_EDGE, 3'd7, 3'd0, 8'h00, 24'h000000, TAG_EMPTY));
        rows.push_back(stim_row(OP_ADD_EDGE, 3'd0, 3'd7, 8'h00, 24'h000000, TAG_EMPTY));
        rows.push_back(stim_row(OP_ADD_VERTEX, 3'd3, 3'd0, 8'h00, 24'h000000, TAG_EMPTY));
        rows.push_back(stim_row(OP_ADD_EDGE, 3'd3, 3'd7, 8'h00, 24'h000000, TAG_EMPTY));
        rows.push_back(stim_row(OP_FORGET, 3'd0, 3'd0, 8'h00, 24'h000000, TAG_EMPTY));
        rows.push_back(stim_row(OP_FORGET, 3'd3, 3'd0, 8'h00, 24'h000000, TAG_EMPTY));
        // forgetting the only component closes the witness
        rows.push_back(known(stim_row(OP_FORGET, 3'd7, 3'd0, 8'h00, 24'h000000, TAG_EMPTY),
                             TAG_CLOSED, 8'h00, 24'h000000, 4'd0, 1'b1, 1'b0));
        // second witness labels do not name their smallest member
        rows.push_back(stim_row(OP_JOIN, 3'd0, 3'd0, 8'h3C, 24'h008D80, TAG_EMPTY));
        rows.push_back(stim_row(OP_ADD_VERTEX, 3'd0, 3'd0, 8'h00, 24'h000000, TAG_EMPTY));
        rows.push_back(stim_row(OP_ADD_EDGE, 3'd0, 3'd5, 8'h00, 24'h000000, TAG_EMPTY));
        rows.push_back(stim_row(OP_FORGET, 3'd6, 3'd0, 8'h00, 24'h000000, TAG_EMPTY));
        rows.push_back(stim_row(OP_JOIN, 3'd0, 3'd0, 8'hFF, 24'hFFFFFF, TAG_GROWING));
        rows.push_back(stim_row(OP_FORGET, 3'd0, 3'd0, 8'h00, 24'h000000, TAG_EMPTY));
        rows.push_back(stim_row(OP_JOIN, 3'd0, 3'd0, 8'h00, 24'h000000, TAG_BROKEN));
        rows.push_back(stim_row(OP_ADD_EDGE, 3'd7, 3'd7, 8'h00, 24'h000000, TAG_EMPTY));
        rows.push_back(stim_row(OP_JOIN, 3'd0, 3'd0, 8'h80, 24'h000000, TAG_CLOSED));

        sender_idle_pct = 30;
        receiver_stall_pct = 50;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
        begin
            send_word(rows[i].w, rows[i].typed, rows[i].want);
        end
        for (int n = 0; n < 800; n++)
        begin
            if (n == 267)
            begin
                sender_idle_pct = 50;
                receiver_stall_pct = 30;
            end
            else if (n == 534)
            begin
                sender_idle_pct = 0;
                receiver_stall_pct = 0;
            end
            send_word(random_word(), 1'b0, '0);
        end
        in_valid <= 1'b0;

        guard = 0;
        while (witness_due.size() != 0 && guard < 5000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (10) @(posedge clk);
        if (witness_due.size() != 0)
        begin
            $error("%0d result words never arrived", witness_due.size());
            failures++;
        end
        if (failures == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/cwu_pkg.sv
hw/rtl/cwu_ctrl.sv
hw/rtl/cwu_datapath.sv
hw/rtl/connectivity_witness_update.sv
hw/rtl/cwu_checker.sv
tb/sv/tb.sv
